// ===== rtl/sliding_window_average_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window average: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, disabled while reset is asserted
`define SWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ===== rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window average package
// Field widths, default depth, state encodings and queue status type.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned AVG_W          = 24;
  localparam int unsigned USED_W         = 7;
  localparam int unsigned FRAC_W         = 8;

  // front end: take a sample, then update ring and running sum
  typedef enum logic {
    FRONT_IDLE,
    FRONT_UPDATE
  } front_state_e;

  // back end: pop, divide, hand result to output register
  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_DONE
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } swa_q_status_t;

endpackage

// ===== rtl/swa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module swa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/swa_front.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: front end
// Accepts samples, keeps the sample ring, fill count and running sum, and
// pushes (sum, count) pairs into the queue toward the divider.
// ----------------------------------------------------------------------------
module swa_front #(
  parameter int unsigned MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int unsigned FW = $clog2(MAX_WINDOW + 1),
  parameter int unsigned SW = swa_pkg::SAMPLE_W + $clog2(MAX_WINDOW)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_i,
  input  swa_pkg::swa_q_status_t              q_status_i,
  output logic                                push_o,
  output logic signed [SW-1:0]                push_sum_o,
  output logic [FW-1:0]                       push_fill_o
);
  import swa_pkg::*;

  localparam int unsigned CW = (FW > CFG_W) ? FW : CFG_W;

  front_state_e         state_q, state_d;
  logic [CFG_W-1:0]     win_size_q;
  logic [IW-1:0]        wr_slot_q, wr_slot_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [IW-1:0]        slot_q;
  logic [FW-1:0]        win_eff;
  logic [IW-1:0]        slot_cur;
  logic [IW-1:0]        slot_inc;
  logic [SAMPLE_W-1:0]  old_sample;
  logic                 win_full;
  logic                 accept;
  logic                 update;

  // effective window: zero counts as one, saturate at ring depth
  always_comb begin
    if (win_size_q == '0) begin
      win_eff = FW'(1);
    end else if (CW'(win_size_q) > CW'(MAX_WINDOW)) begin
      win_eff = FW'(MAX_WINDOW);
    end else begin
      win_eff = FW'(win_size_q);
    end
  end

  assign slot_cur = (FW'(wr_slot_q) >= win_eff) ? '0 : wr_slot_q;
  assign slot_inc = (FW'(slot_q) + FW'(1) >= win_eff) ? '0 : IW'(slot_q + IW'(1));
  assign win_full = (fill_q == win_eff);

  assign accept = in_valid_i && in_ready_o;
  assign update = (state_q == FRONT_UPDATE);

  // ring: oldest sample is read during accept, new one written in update
  swa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW),
    .AW    (IW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (update),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .raddr_i (slot_cur),
    .rdata_o (old_sample)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FRONT_IDLE:   if (accept) state_d = FRONT_UPDATE;
      FRONT_UPDATE: state_d = FRONT_IDLE;
      default:      state_d = FRONT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      FRONT_IDLE:   in_ready_o = !q_status_i.full;
      FRONT_UPDATE: push_o     = 1'b1;
      default:      in_ready_o = 1'b0;
    endcase
  end

  // running sum and fill count update
  always_comb begin
    sum_d     = sum_q + SW'($signed(sample_q));
    fill_d    = fill_q + FW'(1);
    wr_slot_d = slot_inc;
    if (win_full) begin
      sum_d  = sum_q + SW'($signed(sample_q)) - SW'($signed(old_sample));
      fill_d = fill_q;
    end
  end

  assign push_sum_o  = sum_d;
  assign push_fill_o = fill_d;

  // control state; a window size write clears the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FRONT_IDLE;
      win_size_q <= CFG_W'(1);
      wr_slot_q  <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_size_q <= cfg_wdata_i;
        wr_slot_q  <= '0;
        fill_q     <= '0;
        sum_q      <= '0;
      end else if (update) begin
        wr_slot_q <= wr_slot_d;
        fill_q    <= fill_d;
        sum_q     <= sum_d;
      end
    end
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      slot_q   <= slot_cur;
    end
  end

endmodule

// ===== rtl/swa_queue.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: decoupling queue
// Two-entry FIFO carrying (sum, count) pairs from front end to divider.
// ----------------------------------------------------------------------------
module swa_queue #(
  parameter int unsigned DW = 29
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [DW-1:0]          push_data_i,
  input  logic                   pop_i,
  output logic [DW-1:0]          pop_data_o,
  output swa_pkg::swa_q_status_t status_o
);
  import swa_pkg::*;

  logic [DW-1:0] entry_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = entry_q[rd_ptr_q];

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/swa_back.sv =====
// ----------------------------------------------------------------------------
// Sliding window average: back end
// Restoring divider (one quotient bit per cycle) computing sum*256/count,
// truncated toward zero, followed by the output register.
// ----------------------------------------------------------------------------
module swa_back #(
  parameter int unsigned FW = 7,
  parameter int unsigned SW = 22
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swa_pkg::swa_q_status_t            q_status_i,
  input  logic signed [SW-1:0]              pop_sum_i,
  input  logic [FW-1:0]                     pop_fill_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [swa_pkg::AVG_W-1:0]  average_q8_o,
  output logic [swa_pkg::USED_W-1:0]        samples_used_o
);
  import swa_pkg::*;

  localparam int unsigned NW    = SW + FRAC_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  back_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [NW-1:0]      quo_q;
  logic [FW-1:0]      rem_q;
  logic [FW-1:0]      div_q;
  logic               neg_q;
  logic [SW-1:0]      mag;
  logic [FW:0]        rem_shift;
  logic               ge;
  logic [FW-1:0]      rem_next;
  logic [NW-1:0]      res_signed;
  logic               load_out;
  logic               out_valid_q;
  logic [AVG_W-1:0]   avg_q;
  logic [USED_W-1:0]  used_q;

  // magnitude of the sum
  assign mag = pop_sum_i[SW-1] ? (~pop_sum_i + SW'(1)) : pop_sum_i;

  // one restoring step
  assign rem_shift = {rem_q, quo_q[NW-1]};
  assign ge        = (rem_shift >= {1'b0, div_q});
  assign rem_next  = ge ? FW'(rem_shift - {1'b0, div_q}) : rem_shift[FW-1:0];

  assign res_signed = neg_q ? (~quo_q + NW'(1)) : quo_q;
  assign load_out   = (state_q == BACK_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BACK_IDLE: if (!q_status_i.empty) state_d = BACK_DIV;
      BACK_DIV:  if (cnt_q == CNT_W'(1)) state_d = BACK_DONE;
      BACK_DONE: if (load_out) state_d = BACK_IDLE;
      default:   state_d = BACK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = 1'b0;
    unique case (state_q)
      BACK_IDLE: pop_o = !q_status_i.empty;
      BACK_DIV:  pop_o = 1'b0;
      BACK_DONE: pop_o = 1'b0;
      default:   pop_o = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= CNT_W'(NW);
      end else if (state_q == BACK_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quo_q  <= {mag, {FRAC_W{1'b0}}};
      rem_q  <= '0;
      div_q  <= pop_fill_i;
      neg_q  <= pop_sum_i[SW-1];
      used_q <= USED_W'(pop_fill_i);
    end else if (state_q == BACK_DIV) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      avg_q          <= res_signed[AVG_W-1:0];
      samples_used_o <= used_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_q8_o = avg_q;

endmodule

// ===== rtl/sliding_window_average.sv =====
// ----------------------------------------------------------------------------
// Sliding window average (simple moving average), top level
// Front end keeps the sample window, a queue decouples it from the divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, sample_i): one signed 16-bit sample
//   per transaction. Output channel (out_valid_o/out_ready_i): one result per
//   sample, average_q8_o (mean, 8 fraction bits, truncated toward zero) and
//   samples_used_o (samples in the mean).
//   cfg_we_i/cfg_wdata_i write the window size and clear the window; write
//   only while no transaction is in flight.
//   Throughput is set by the bit-serial restoring divider, which produces one
//   quotient bit a cycle and takes the next (sum, count) pair only after its
//   result has moved to the output register. The front end reads the ring
//   on accept, then writes it in its update state, taking no sample between.
//   Reset: window size 1, window empty; ring contents need no clearing since
//   an entry is only read back after it has been written.
//   Receiver stall: the result waits in the output register, the divider
//   holds its finished result, the two-entry queue fills and then in_ready_o
//   drops until space frees up.
// ----------------------------------------------------------------------------
module sliding_window_average #(
  parameter int unsigned MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [swa_pkg::AVG_W-1:0]    average_q8_o,
  output logic [swa_pkg::USED_W-1:0]          samples_used_o
);
  import swa_pkg::*;

  `include "sliding_window_average_defines.svh"

  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int unsigned DW = SW + FW;

  swa_q_status_t        q_status;
  logic                 push;
  logic signed [SW-1:0] push_sum;
  logic [FW-1:0]        push_fill;
  logic                 pop;
  logic [DW-1:0]        pop_data;

  // window bookkeeping
  swa_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .IW         (IW),
    .FW         (FW),
    .SW         (SW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_sum_o  (push_sum),
    .push_fill_o (push_fill)
  );

  // decoupling queue
  swa_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_sum, push_fill}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // divider and output register
  swa_back #(
    .FW (FW),
    .SW (SW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .pop_sum_i      ($signed(pop_data[DW-1:FW])),
    .pop_fill_i     (pop_data[FW-1:0]),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_q8_o   (average_q8_o),
    .samples_used_o (samples_used_o)
  );

  // after an accept the front end is in its update state: not ready, and pushing
  `SWA_ASSERT_NXT(a_front_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && push)
  // queue never pushed while full without a pop, nor popped while empty
  `SWA_ASSERT_IMP(a_queue_bounds, clk_i, rst_ni, 1'b1,
                  !(push && q_status.full && !pop) && !(pop && q_status.empty))
  // count carried with a result is never zero
  `SWA_ASSERT_IMP(a_fill_nonzero, clk_i, rst_ni, push, push_fill != '0)

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sliding window average testbench
// A short table of samples and window sizes comes first: reset state, window
// sizes zero, small, full and oversized, extreme samples and negative means
// that truncate toward zero. Random phases follow, each with a fresh window
// size. Every result is checked in order against the row's expected value
// where the table gives one, else against a bit-accurate window model,
// with random bursts on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;

  import swa_pkg::*;

  localparam int WIN_MAX      = MAX_WINDOW_DEF;
  localparam int RAND_ITEMS   = 650;
  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES  = 60;    // extra wait after the last result
  localparam int SETTLE       = 4;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 22;
  localparam int N_EDGE_WIN   = 5;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg;
    logic [USED_W-1:0]       used;
  } mean_t;

  // one row of the directed part; exp_* only used when known is set
  typedef struct packed {
    bit                         cfg_wr;
    logic [CFG_W-1:0]           cfg_val;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known;
    logic signed [AVG_W-1:0]    exp_avg;
    logic [USED_W-1:0]          exp_used;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // reset state: window of one
    '{1'b0, 7'd0,   16'sd32767, 1'b1, 24'sd8388352, 7'd1},
    '{1'b0, 7'd0,   16'h8000,   1'b1, 24'h800000,   7'd1},
    '{1'b0, 7'd0,   -16'sd1,    1'b1, -24'sd256,    7'd1},
    '{1'b0, 7'd0,   16'sd0,     1'b1, 24'sd0,       7'd1},
    // window size zero acts as one
    '{1'b1, 7'd0,   16'sd5,     1'b1, 24'sd1280,    7'd1},
    '{1'b0, 7'd0,   16'sd7,     1'b1, 24'sd1792,    7'd1},
    // window of three: negative means truncate toward zero, then wrap
    '{1'b1, 7'd3,   -16'sd1,    1'b1, -24'sd256,    7'd1},
    '{1'b0, 7'd0,   16'sd0,     1'b1, -24'sd128,    7'd2},
    '{1'b0, 7'd0,   16'sd0,     1'b1, -24'sd85,     7'd3},
    '{1'b0, 7'd0,   16'sd0,     1'b1, 24'sd0,       7'd3},
    '{1'b0, 7'd0,   16'sd1,     1'b1, 24'sd85,      7'd3},
    // oversized window saturates to the ring depth
    '{1'b1, 7'd127, 16'sd32767, 1'b1, 24'sd8388352, 7'd1},
    '{1'b0, 7'd0,   16'h8000,   1'b1, -24'sd128,    7'd2},
    '{1'b0, 7'd0,   16'h5555,   1'b0, 24'sd0,       7'd0},
    '{1'b0, 7'd0,   16'hAAAA,   1'b0, 24'sd0,       7'd0},
    // full-depth window
    '{1'b1, 7'd64,  16'h7FFE,   1'b0, 24'sd0,       7'd0},
    '{1'b0, 7'd0,   16'h8001,   1'b0, 24'sd0,       7'd0},
    // window of two drops the oldest on every sample once full
    '{1'b1, 7'd2,   16'sd100,   1'b1, 24'sd25600,   7'd1},
    '{1'b0, 7'd0,   16'sd101,   1'b1, 24'sd25728,   7'd2},
    '{1'b0, 7'd0,   16'sd102,   1'b1, 24'sd25984,   7'd2},
    // just past the ring depth
    '{1'b1, 7'd65,  16'h00FF,   1'b0, 24'sd0,       7'd0},
    '{1'b0, 7'd0,   16'hFF00,   1'b0, 24'sd0,       7'd0}
  };

  localparam logic [CFG_W-1:0] EDGE_WINDOWS [N_EDGE_WIN] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [AVG_W-1:0]    average_q8_o;
  logic [USED_W-1:0]          samples_used_o;

  sliding_window_average DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_q8_o   (average_q8_o),
    .samples_used_o (samples_used_o)
  );

  // window model state
  logic signed [SAMPLE_W-1:0] ring_model [WIN_MAX];
  logic [5:0]                 slot_model = '0;
  logic [USED_W-1:0]          fill_model = '0;
  logic signed [21:0]         sum_model  = '0;
  logic [CFG_W-1:0]           wsize_model = 7'd1;

  mean_t pending_means [$];
  int    err_count   = 0;
  int    idle_cycles = 0;
  int    burst_left  = 0;
  bit    valid_up    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the window model by one sample and return the mean it gives
  function automatic mean_t advance_window(input logic signed [SAMPLE_W-1:0] s);
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] slot;
    longint           scaled;
    mean_t            r;
    w = (wsize_model == 0) ? 7'd1 : (wsize_model > WIN_MAX) ? 7'(WIN_MAX) : wsize_model;
    slot = {1'b0, slot_model};
    if (slot >= w) slot = '0;
    if (fill_model < w) fill_model = fill_model + 1'b1;
    else sum_model = sum_model - ring_model[slot[5:0]];
    ring_model[slot[5:0]] = s;
    sum_model = sum_model + s;
    slot = slot + 1'b1;
    if (slot >= w) slot = '0;
    slot_model = slot[5:0];
    scaled = (longint'(sum_model) * 256) / longint'(fill_model);
    r.avg  = scaled[AVG_W-1:0];
    r.used = fill_model;
    return r;
  endfunction

  // Random samples, often extreme, or only extremes; pushes the sum to its limits
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit extremes_only);
    int unsigned pick;
    pick = extremes_only ? $urandom_range(0, 1) : $urandom_range(0, 7);
    case (pick)
      0: return 16'sd32767;
      1: return 16'h8000;
      2: return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain();
    lower_valid();
    @(posedge clk_i);
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Window size write, only with the block idle; also clears the model window
  task automatic set_window(input logic [CFG_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CFG_W'($urandom);
    wsize_model = v;
    slot_model  = '0;
    fill_model  = '0;
    sum_model   = '0;
  endtask

  // Offer one sample, wait for the transaction, record what should come back
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input bit known,
                             input mean_t known_res);
    mean_t modeled;
    in_valid_i <= 1'b1;
    sample_i   <= s;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    modeled = advance_window(s);
    pending_means.insert(pending_means.size(), known ? known_res : modeled);
  endtask

  // Bursts of back-to-back samples separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 12);
      lower_valid();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    mean_t            known_res;
    dir_row_t         row;
    logic [CFG_W-1:0] wsel;
    bit               extremes_only;
    int               rand_sent;
    int               phase;
    int               n_items;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.cfg_wr) set_window(row.cfg_val);
      known_res.avg  = row.exp_avg;
      known_res.used = row.exp_used;
      push_sample(row.sample, row.known, known_res);
      pace();
    end

    // random phases, each behind a fresh window size
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (phase < N_EDGE_WIN) wsel = EDGE_WINDOWS[phase];
      else if ($urandom_range(0, 2) == 0) wsel = CFG_W'($urandom_range(1, 8));
      else wsel = CFG_W'($urandom_range(0, 127));
      set_window(wsel);
      extremes_only = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(30, 100);
      for (int j = 0; j < n_items && rand_sent < RAND_ITEMS; j++) begin
        push_sample(pick_sample(extremes_only), 1'b0, known_res);
        rand_sent++;
        if ($urandom_range(0, 49) == 0) drain();
        else pace();
      end
      phase++;
    end

    lower_valid();
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_means.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: ready pattern switches between open, coin-flip, sparse and held
  initial begin : rx_pattern
    rx_mode_e mode;
    int       len;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(4, 60);
      repeat (len) begin
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= 1'b0;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Result check against the oldest pending mean
  always @(posedge clk_i) begin : result_check
    mean_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: average_q8 %0d samples_used %0d",
                   average_q8_o, samples_used_o);
      end else begin
        want = pending_means[0];
        pending_means.delete(0);
        if (average_q8_o !== want.avg || samples_used_o !== want.used) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("wrong result: average_q8 exp %0d got %0d, samples_used exp %0d got %0d",
                     want.avg, average_q8_o, want.used, samples_used_o);
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
